// ===== design/tvc_pkg.sv =====
// shared types, codes and ordering helpers for the typed value comparator
package tvc_pkg;

  localparam int unsigned OperandWidth = 64;

  typedef enum logic [3:0] {
    ET_BOOL    = 4'd0,
    ET_INT8    = 4'd1,
    ET_INT16   = 4'd2,
    ET_INT32   = 4'd3,
    ET_INT64   = 4'd4,
    ET_UINT8   = 4'd5,
    ET_UINT16  = 4'd6,
    ET_UINT32  = 4'd7,
    ET_UINT64  = 4'd8,
    ET_FLOAT   = 4'd9,
    ET_DOUBLE  = 4'd10,
    ET_CFLOAT  = 4'd11,
    ET_CDOUBLE = 4'd12
  } elem_type_t;

  typedef enum logic [2:0] {
    OP_LT = 3'd0,
    OP_LE = 3'd1,
    OP_EQ = 3'd2,
    OP_NE = 3'd3,
    OP_GE = 3'd4,
    OP_GT = 3'd5
  } compare_op_t;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2,
    ORD_UN = 2'd3
  } ord_t;

  typedef enum logic {
    REG_ELEM_TYPE  = 1'b0,
    REG_COMPARE_OP = 1'b1
  } reg_idx_t;

  function automatic ord_t ord_u64(input logic [63:0] x, input logic [63:0] y);
    if (x < y) return ORD_LT;
    if (x > y) return ORD_GT;
    return ORD_EQ;
  endfunction

  // monotone key of a non-nan value; both zeros map alike
  function automatic logic [63:0] fp_key64(input logic [63:0] x);
    if (x[62:0] == '0) return 64'h8000_0000_0000_0000;
    if (x[63]) return ~x;
    return {1'b1, x[62:0]};
  endfunction

  function automatic logic [31:0] fp_key32(input logic [31:0] x);
    if (x[30:0] == '0) return 32'h8000_0000;
    if (x[31]) return ~x;
    return {1'b1, x[30:0]};
  endfunction

  function automatic ord_t ord_fp(input logic [63:0] x, input logic [63:0] y,
                                  input logic dbl);
    if (dbl) begin
      if (x[62:0] > 63'h7FF0_0000_0000_0000 || y[62:0] > 63'h7FF0_0000_0000_0000)
        return ORD_UN;
      return ord_u64(fp_key64(x), fp_key64(y));
    end
    if (x[30:0] > 31'h7F80_0000 || y[30:0] > 31'h7F80_0000) return ORD_UN;
    return ord_u64({32'd0, fp_key32(x[31:0])}, {32'd0, fp_key32(y[31:0])});
  endfunction

  function automatic logic apply_op(input compare_op_t op, input ord_t o);
    case (op)
      OP_LT:   return o == ORD_LT;
      OP_LE:   return o == ORD_LT || o == ORD_EQ;
      OP_EQ:   return o == ORD_EQ;
      OP_NE:   return o != ORD_EQ;
      OP_GE:   return o == ORD_GT || o == ORD_EQ;
      OP_GT:   return o == ORD_GT;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ===== design/typed_value_comparator_core.sv =====
// typed value comparator: one relation test per beat on integer, float or complex operands
// One beat is accepted per cycle while out_ready stays high (full throughput), and its
// answer passes from a registered input stage through one compare stage into the output
// register. elem_type and compare_op are written through the cfg channel; the user must
// write them only while the block is idle, and the block itself does not enforce it.
module typed_value_comparator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [tvc_pkg::OperandWidth-1:0] in_a_real,
  input  logic [tvc_pkg::OperandWidth-1:0] in_a_imag,
  input  logic [tvc_pkg::OperandWidth-1:0] in_b_real,
  input  logic [tvc_pkg::OperandWidth-1:0] in_b_imag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_holds
);
  import tvc_pkg::*;

  elem_type_t  elem_type_r;
  compare_op_t compare_op_r;
  logic        s1_valid_r;
  logic [63:0] ar_r, ai_r, br_r, bi_r;
  logic        out_valid_r, out_holds_r;
  logic        s1_ready, out_load;
  logic        holds_nxt;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || out_load;
  assign in_ready  = s1_ready;
  assign out_valid = out_valid_r;
  assign out_holds = out_holds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r  <= ET_BOOL;
      compare_op_r <= OP_LT;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ELEM_TYPE) elem_type_r <= elem_type_t'(cfg_data);
      else compare_op_r <= compare_op_t'(cfg_data[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (out_load) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      ar_r <= in_a_real;
      ai_r <= in_a_imag;
      br_r <= in_b_real;
      bi_r <= in_b_imag;
    end
    if (out_load && s1_valid_r) out_holds_r <= holds_nxt;
  end

  always_comb begin
    ord_t ore, oim;
    logic dbl;
    dbl = (elem_type_r == ET_DOUBLE) || (elem_type_r == ET_CDOUBLE);
    ore = ord_fp(ar_r, br_r, dbl);
    oim = ord_fp(ai_r, bi_r, dbl);
    case (elem_type_r)
      ET_BOOL, ET_UINT8:
        holds_nxt = apply_op(compare_op_r, ord_u64({56'd0, ar_r[7:0]}, {56'd0, br_r[7:0]}));
      ET_UINT16:
        holds_nxt = apply_op(compare_op_r, ord_u64({48'd0, ar_r[15:0]}, {48'd0, br_r[15:0]}));
      ET_UINT32:
        holds_nxt = apply_op(compare_op_r, ord_u64({32'd0, ar_r[31:0]}, {32'd0, br_r[31:0]}));
      ET_UINT64:
        holds_nxt = apply_op(compare_op_r, ord_u64(ar_r, br_r));
      // signed: flip the sign bit to get an order-preserving unsigned key
      ET_INT8:
        holds_nxt = apply_op(compare_op_r, ord_u64({56'd0, ~ar_r[7], ar_r[6:0]},
                                                   {56'd0, ~br_r[7], br_r[6:0]}));
      ET_INT16:
        holds_nxt = apply_op(compare_op_r, ord_u64({48'd0, ~ar_r[15], ar_r[14:0]},
                                                   {48'd0, ~br_r[15], br_r[14:0]}));
      ET_INT32:
        holds_nxt = apply_op(compare_op_r, ord_u64({32'd0, ~ar_r[31], ar_r[30:0]},
                                                   {32'd0, ~br_r[31], br_r[30:0]}));
      ET_INT64:
        holds_nxt = apply_op(compare_op_r, ord_u64({~ar_r[63], ar_r[62:0]},
                                                   {~br_r[63], br_r[62:0]}));
      ET_FLOAT, ET_DOUBLE:
        holds_nxt = apply_op(compare_op_r, ore);
      ET_CFLOAT, ET_CDOUBLE: begin
        if (compare_op_r == OP_EQ) holds_nxt = (ore == ORD_EQ) && (oim == ORD_EQ);
        else if (compare_op_r == OP_NE) holds_nxt = !((ore == ORD_EQ) && (oim == ORD_EQ));
        else holds_nxt = apply_op(compare_op_r, (ore == ORD_EQ) ? oim : ore);
      end
      default: holds_nxt = 1'b0;
    endcase
  end

`ifndef SYNTH
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && s1_valid_r) |=> out_valid_r)
    else $error("result register missed a beat");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_holds_r)))
    else $error("stalled result changed");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(ar_r) && $stable(br_r)))
    else $error("stalled input stage changed");
`endif

endmodule
